// ===== rtl/kmeans_anomaly_classifier_assert.svh =====
// assertion helpers, clocked on clock and disabled during reset
`ifndef KMEANS_ANOMALY_CLASSIFIER_ASSERT_SVH
`define KMEANS_ANOMALY_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define KAC_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kac assertion failed");

// next-cycle implication
`define KAC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kac assertion failed");

`endif

// ===== rtl/kac_pkg.sv =====
package kac_pkg;

   localparam int NUM_CLUSTERS  = 4;
   localparam int FEATURE_COUNT = 51;

   localparam int KIND_W  = 3;
   localparam int CLUS_W  = 4;
   localparam int FIDX_W  = 6;
   localparam int VALUE_W = 64;
   localparam int DIST_W  = 63;

   localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
   localparam int CLU_AW  = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
   localparam int CNT_W   = $clog2(NUM_CLUSTERS + 1);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CLUSTERS - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_CLUSTERS);
   localparam logic [FIDX_W:0]  FEAT_LIM = (FIDX_W + 1)'(FEATURE_COUNT);
   localparam logic [CLUS_W:0]  CLUS_LIM = (CLUS_W + 1)'(NUM_CLUSTERS);

   localparam logic [DIST_W-1:0] SAT63 = {DIST_W{1'b1}};

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   localparam logic [KIND_W-1:0] KIND_CENTROID = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MEAN     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SCALE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_THRESH   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FEATURE  = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CLUS_W-1:0]  cluster;
      logic [FIDX_W-1:0]  feature_index;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               in_range;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic              is_baseline;
      logic              has_cluster;
      logic [CLUS_W-1:0] nearest_cluster;
      logic [DIST_W-1:0] squared_distance;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic ovf;
      ovf = (x[63:31] != {33{1'b0}}) && (x[63:31] != {33{1'b1}});
      if (ovf) begin
         sat32 = x[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

endpackage

// ===== rtl/kac_ram.sv =====
module kac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kac_front.sv =====
module kac_front import kac_pkg::*; (
   input  logic               start,
   output logic               busy,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [CLUS_W-1:0]  req_cluster,
   input  logic [FIDX_W-1:0]  req_feature_index,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_last,
   input  logic               q_full,
   output logic               q_push,
   output entry_type          q_entry
);

   logic fi_ok;
   logic cl_ok;
   logic keep;

   always_comb begin
      fi_ok = {1'b0, req_feature_index} < FEAT_LIM;
      cl_ok = {1'b0, req_cluster} < CLUS_LIM;
      q_entry.kind          = req_kind;
      q_entry.cluster       = req_cluster;
      q_entry.feature_index = req_feature_index;
      q_entry.value         = req_value;
      q_entry.last          = req_last;
      q_entry.in_range      = fi_ok;
      keep = 1'b0;
      case (req_kind)
         KIND_CENTROID: begin
            q_entry.in_range = fi_ok && cl_ok;
            keep = fi_ok && cl_ok;
         end
         KIND_MEAN, KIND_SCALE: begin
            keep = fi_ok;
         end
         KIND_THRESH: begin
            q_entry.in_range = cl_ok;
            keep = cl_ok;
         end
         // out-of-range elements still travel, they may close a vector
         KIND_FEATURE: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign busy   = q_full;
   assign q_push = start && !q_full && keep;

endmodule

// ===== rtl/kac_queue.sv =====
module kac_queue import kac_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

   entry_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full      = count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

endmodule

// ===== rtl/kac_back.sv =====
`include "kmeans_anomaly_classifier_assert.svh"

module kac_back import kac_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      model_ready,
   input  logic      q_not_empty,
   input  entry_type q_head,
   output logic      q_pop,
   output rsp_type   rsp
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;
   localparam logic [2:0] S_NORM  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_SQ    = 3'd4;
   localparam logic [2:0] S_ACC   = 3'd5;
   localparam logic [2:0] S_MIN   = 3'd6;
   localparam logic [2:0] S_RES   = 3'd7;

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         k_ff, k_in;
   logic                     last_ff, last_in;
   logic [VALUE_W-1:0]       value_ff, value_in;
   logic signed [31:0]       diff_ff, diff_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [31:0]       n_ff, n_in;
   logic [64:0]              sq_ff, sq_in;
   logic [DIST_W-1:0]        acc_ff [NUM_CLUSTERS];
   logic [DIST_W-1:0]        acc_in [NUM_CLUSTERS];
   logic [CLU_AW-1:0]        best_ff, best_in;
   logic [DIST_W-1:0]        bd_ff, bd_in;
   logic [VALUE_W-1:0]       thr_ff [NUM_CLUSTERS];
   rsp_type                  rsp_ff, rsp_in;

   logic                     is_elem;
   logic                     rd_en;
   logic [FEAT_AW-1:0]       ram_addr;
   logic                     wr_cent, wr_mean, wr_scale, wr_thr;
   logic [31:0]              mean_rd, scale_rd;
   logic [31:0]              cen_rd [NUM_CLUSTERS];
   logic [CLU_AW-1:0]        k_idx;
   logic [CLU_AW-1:0]        head_cl;
   logic signed [32:0]       v_diff;
   logic signed [31:0]       v_sat;
   logic signed [32:0]       d;
   logic [32:0]              m;
   logic [64:0]              sq_full;
   logic [DIST_W-1:0]        sq_sat;
   logic [DIST_W:0]          sum;
   logic [VALUE_W-1:0]       thr;
   logic                     acc_any;

   assign ram_addr = q_head.feature_index[FEAT_AW-1:0];
   assign head_cl  = q_head.cluster[CLU_AW-1:0];
   assign k_idx    = k_ff[CLU_AW-1:0];
   assign q_pop    = (state_ff == S_IDLE) && q_not_empty;
   assign is_elem  = q_head.kind == KIND_FEATURE;
   assign rd_en    = q_pop && is_elem && q_head.in_range;
   assign wr_cent  = q_pop && (q_head.kind == KIND_CENTROID);
   assign wr_mean  = q_pop && (q_head.kind == KIND_MEAN);
   assign wr_scale = q_pop && (q_head.kind == KIND_SCALE);
   assign wr_thr   = q_pop && (q_head.kind == KIND_THRESH);

   kac_ram #(.WIDTH(32), .DEPTH(FEATURE_COUNT)) u_mean (
      .clock, .wr_en(wr_mean), .wr_addr(ram_addr), .wr_data(q_head.value[31:0]),
      .rd_en, .rd_addr(ram_addr), .rd_data(mean_rd)
   );

   kac_ram #(.WIDTH(32), .DEPTH(FEATURE_COUNT)) u_scale (
      .clock, .wr_en(wr_scale), .wr_addr(ram_addr), .wr_data(q_head.value[31:0]),
      .rd_en, .rd_addr(ram_addr), .rd_data(scale_rd)
   );

   for (genvar g = 0; g < NUM_CLUSTERS; g++) begin : g_cent
      kac_ram #(.WIDTH(32), .DEPTH(FEATURE_COUNT)) u_cent (
         .clock,
         .wr_en(wr_cent && (head_cl == CLU_AW'(g))),
         .wr_addr(ram_addr), .wr_data(q_head.value[31:0]),
         .rd_en, .rd_addr(ram_addr), .rd_data(cen_rd[g])
      );
   end

   always_ff @(posedge clock) begin
      if (wr_thr) begin
         thr_ff[head_cl] <= q_head.value;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      value_in = value_ff;
      diff_in  = diff_ff;
      prod_in  = prod_ff;
      n_in     = n_ff;
      sq_in    = sq_ff;
      best_in  = best_ff;
      bd_in    = bd_ff;
      for (int i = 0; i < NUM_CLUSTERS; i++) begin
         acc_in[i] = acc_ff[i];
      end
      rsp_in       = rsp_ff;
      rsp_in.valid = 1'b0;

      v_sat   = sat32(value_ff);
      v_diff  = {v_sat[31], v_sat} - {mean_rd[31], mean_rd};
      d       = {n_ff[31], n_ff} - {cen_rd[k_idx][31], cen_rd[k_idx]};
      m       = d[32] ? 33'(-d) : 33'(d);
      sq_full = m * m;
      sq_sat  = (sq_ff > {2'b00, SAT63}) ? SAT63 : sq_ff[DIST_W-1:0];
      sum     = {1'b0, acc_ff[k_idx]} + {1'b0, sq_sat};
      thr     = thr_ff[best_ff];

      case (state_ff)
         S_IDLE: begin
            if (q_pop && is_elem) begin
               last_in  = q_head.last;
               value_in = q_head.value;
               if (q_head.in_range) begin
                  state_in = S_RD;
               end else if (q_head.last) begin
                  state_in = S_MIN;
                  best_in  = '0;
                  bd_in    = acc_ff[0];
                  k_in     = CNT_W'(1);
               end
            end
         end
         S_RD: begin
            diff_in  = sat32(64'(v_diff));
            state_in = S_NORM;
         end
         S_NORM: begin
            prod_in  = diff_ff * $signed(scale_rd);
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            // arithmetic shift rounds toward minus infinity
            n_in     = sat32(prod_ff >>> 16);
            k_in     = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            sq_in    = sq_full;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in[k_idx] = sum[DIST_W] ? SAT63 : sum[DIST_W-1:0];
            if (k_ff == CNT_LAST) begin
               if (last_ff) begin
                  state_in = S_MIN;
                  best_in  = '0;
                  bd_in    = (k_idx == '0) ? acc_in[0] : acc_ff[0];
                  k_in     = CNT_W'(1);
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_SQ;
            end
         end
         S_MIN: begin
            if (k_ff == CNT_END) begin
               state_in = S_RES;
            end else begin
               if (acc_ff[k_idx] < bd_ff) begin
                  bd_in   = acc_ff[k_idx];
                  best_in = k_idx;
               end
               k_in = k_ff + 1'b1;
            end
         end
         S_RES: begin
            rsp_in.valid = 1'b1;
            if (model_ready) begin
               rsp_in.is_baseline      = !thr[63] && ({1'b0, bd_ff} <= thr);
               rsp_in.has_cluster      = 1'b1;
               rsp_in.nearest_cluster  = CLUS_W'(best_ff);
               rsp_in.squared_distance = bd_ff;
            end else begin
               rsp_in.is_baseline      = 1'b1;
               rsp_in.has_cluster      = 1'b0;
               rsp_in.nearest_cluster  = '0;
               rsp_in.squared_distance = '0;
            end
            for (int i = 0; i < NUM_CLUSTERS; i++) begin
               acc_in[i] = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         rsp_ff   <= '0;
         for (int i = 0; i < NUM_CLUSTERS; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         rsp_ff   <= rsp_in;
         for (int i = 0; i < NUM_CLUSTERS; i++) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      value_ff <= value_in;
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      n_ff     <= n_in;
      sq_ff    <= sq_in;
      best_ff  <= best_in;
      bd_ff    <= bd_in;
   end

   assign rsp = rsp_ff;

   always_comb begin
      acc_any = 1'b0;
      for (int i = 0; i < NUM_CLUSTERS; i++) begin
         acc_any = acc_any | (acc_ff[i] != '0);
      end
   end

   `KAC_ASSERT_NEXT(a_acc_cleared, rsp_ff.valid, !acc_any)
   `KAC_ASSERT_NEXT(a_single_strobe, rsp_ff.valid, !rsp_ff.valid)
   `KAC_ASSERT_NOW(a_no_cluster_zero,
      rsp_ff.valid && !rsp_ff.has_cluster,
      rsp_ff.is_baseline && (rsp_ff.squared_distance == '0))
   `KAC_ASSERT_NOW(a_lane_range, (state_ff == S_SQ) || (state_ff == S_ACC),
      k_ff < CNT_END)
   `KAC_ASSERT_NOW(a_pop_nonempty, q_pop, q_not_empty)

endmodule

// ===== rtl/kmeans_anomaly_classifier.sv =====
// channel    ports                                   handshake
// request    start, busy, req_*                      beat when start & !busy
// response   rsp_valid, rsp_*                        one-cycle strobe, no stall
// config     csr_valid, csr_ready, csr_model_ready   beat when valid & ready
//
// load beats are written to the back end when popped; a feature element is read,
// normalised, shifted, then squared and accumulated per cluster on the one shared
// squaring multiplier and adder; a last element adds the minimum search and result
// a two-entry queue decouples request decode from the back end; busy means queue full
// synchronous active-high reset clears control state and the distance accumulators
module kmeans_anomaly_classifier import kac_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [CLUS_W-1:0]  req_cluster,
   input  logic [FIDX_W-1:0]  req_feature_index,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               req_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_model_ready,
   output logic               rsp_valid,
   output logic               rsp_is_baseline,
   output logic               rsp_has_cluster,
   output logic [CLUS_W-1:0]  rsp_nearest_cluster,
   output logic [DIST_W-1:0]  rsp_squared_distance
);

   logic      model_ready_ff, model_ready_in;
   logic      q_full, q_push, q_pop, q_not_empty;
   entry_type q_entry, q_head;
   rsp_type   rsp;

   assign csr_ready      = 1'b1;
   assign model_ready_in = (csr_valid && csr_ready) ? csr_model_ready : model_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ready_ff <= 1'b0;
      end else begin
         model_ready_ff <= model_ready_in;
      end
   end

   kac_front u_front (
      .start, .busy, .req_kind, .req_cluster, .req_feature_index, .req_value,
      .req_last, .q_full, .q_push, .q_entry
   );

   kac_queue u_queue (
      .clock, .reset, .push(q_push), .push_entry(q_entry), .pop(q_pop),
      .full(q_full), .not_empty(q_not_empty), .head(q_head)
   );

   kac_back u_back (
      .clock, .reset, .model_ready(model_ready_ff), .q_not_empty, .q_head,
      .q_pop, .rsp
   );

   assign rsp_valid            = rsp.valid;
   assign rsp_is_baseline      = rsp.is_baseline;
   assign rsp_has_cluster      = rsp.has_cluster;
   assign rsp_nearest_cluster  = rsp.nearest_cluster;
   assign rsp_squared_distance = rsp.squared_distance;

endmodule
